// ===== rtl/core/aeve_pkg.sv =====
package aeve_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_INIT   = 2'd2;

    localparam logic [1:0] CFG_SKIP   = 2'd0;
    localparam logic [1:0] CFG_SPAN   = 2'd1;
    localparam logic [1:0] CFG_HIST   = 2'd2;
    localparam logic [1:0] CFG_THRESH = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] position;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] velocity;
        logic [5:0]         used_count;
    } out_item_t;

    // Divider handshake between the sequencer and the divide unit.
    typedef struct packed {
        logic               start;
        logic signed [23:0] dividend;
        logic [5:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [23:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/adaptive_encoder_velocity_estimator.sv =====
// Encoder velocity estimator. Positions go into a ring memory of RING_DEPTH
// entries. A sample request is one write. An init request sweeps every
// entry. A tick request reads the ring through its single read port, with
// two reads and one accumulate per delta walked (recent_span-1 in the first
// pass plus up to history_steps in the history walk), then runs the bit-serial
// divider and finishes. When the count is one or less the divider is
// skipped. A tick also stays longer while an earlier result still waits in
// the output register.
// One item is in work at a time. The finished result sits in an output
// register, and the next item is taken while it waits to be transferred.
module adaptive_encoder_velocity_estimator #(
    parameter int RING_DEPTH = aeve_pkg::RING_DEPTH_DEF,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  aeve_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output aeve_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data
);
    import aeve_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_FILL, S_RD_A, S_RD_B, S_ACC, S_DIV_GO, S_DIV_WAIT, S_FINISH, S_HOLD
    } state_t;

    logic       skip_reg;
    logic [4:0] span_reg;
    logic [3:0] hist_reg;
    logic [5:0] thresh_reg;

    state_t              state_reg, state_next;
    logic [AW-1:0]       newest_reg, newest_next;
    logic signed [15:0]  vel_reg, vel_next;
    logic [AW-1:0]       idx_reg, idx_next;   // earlier slot of current delta
    logic [4:0]          k_reg, k_next;       // remaining deltas in the pass
    logic                hpass_reg, hpass_next;
    logic signed [23:0]  sum_reg, sum_next;
    logic [6:0]          cnt_reg, cnt_next;
    logic signed [15:0]  posa_reg, posa_next;
    logic signed [15:0]  pos_reg, pos_next;
    logic                ovalid_reg, ovalid_next;
    out_item_t           odata_reg, odata_next;

    logic                we;
    logic [AW-1:0]       waddr, raddr;
    logic signed [15:0]  wdata, rdata;
    logic [AW-1:0]       later;
    logic signed [15:0]  delta;
    logic signed [16:0]  vsum;
    logic signed [16:0]  mean;
    div_req_t            dreq;
    div_rsp_t            drsp;

    aeve_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    aeve_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in_stall = (state_reg != S_IDLE);
    assign later    = hpass_reg ? idx_reg + AW'(3) : idx_reg + AW'(1);
    assign delta    = posa_reg - rdata;

    always_comb
    begin
        state_next  = state_reg;
        newest_next = newest_reg;
        vel_next    = vel_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        hpass_next  = hpass_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        posa_next   = posa_reg;
        pos_next    = pos_reg;
        ovalid_next = ovalid_reg && out_stall;
        odata_next  = odata_reg;
        we          = 1'b0;
        waddr       = newest_reg + AW'(1);
        wdata       = in_data.position;
        raddr       = later;
        dreq        = '0;
        mean        = '0;
        vsum        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    case (in_data.req_type)
                        REQ_SAMPLE:
                        begin
                            we          = 1'b1;
                            newest_next = newest_reg + AW'(1);
                        end
                        REQ_INIT:
                        begin
                            pos_next   = in_data.position;
                            idx_next   = '0;
                            state_next = S_FILL;
                        end
                        REQ_TICK:
                        begin
                            // First pass starts recent_span slots before newest.
                            idx_next   = newest_reg - AW'(span_reg);
                            sum_next   = '0;
                            cnt_next   = '0;
                            hpass_next = 1'b0;
                            if (span_reg > 5'd1)
                            begin
                                k_next     = span_reg - 5'd1;
                                state_next = S_RD_A;
                            end
                            else
                            begin
                                k_next     = 5'd0;
                                state_next = S_ACC;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = pos_reg;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(RING_DEPTH - 1))
                begin
                    newest_next = AW'(RING_DEPTH - 1);
                    vel_next    = '0;
                    state_next  = S_IDLE;
                end
            end
            S_RD_A:
            begin
                raddr      = later;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                posa_next  = rdata;
                raddr      = idx_reg;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                // k_reg == 0 here means no delta was read (entry into a pass).
                if (k_reg != 5'd0)
                begin
                    if (!(skip_reg && delta == 16'sd0))
                    begin
                        sum_next = sum_reg + 24'(delta);
                        cnt_next = hpass_reg ? cnt_reg + 7'd3 : cnt_reg + 7'd1;
                    end
                    k_next = k_reg - 5'd1;
                end
                state_next = S_RD_A;
                if (k_reg <= 5'd1)
                begin
                    if (!hpass_reg)
                    begin
                        // Switch to the history walk, top is one before start.
                        if (cnt_next < {1'b0, thresh_reg} && hist_reg != 4'd0)
                        begin
                            hpass_next = 1'b1;
                            idx_next   = newest_reg - AW'(span_reg) - AW'(1);
                            k_next     = {1'b0, hist_reg};
                        end
                        else
                        begin
                            state_next = S_DIV_GO;
                        end
                    end
                    else
                    begin
                        state_next = S_DIV_GO;
                    end
                end
                else if (hpass_reg)
                begin
                    if (cnt_next >= {1'b0, thresh_reg})
                    begin
                        state_next = S_DIV_GO;
                    end
                    else
                    begin
                        idx_next = idx_reg - AW'(3);
                    end
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
                if (hpass_reg && k_reg == 5'd1)
                begin
                    state_next = S_DIV_GO;
                end
            end
            S_DIV_GO:
            begin
                if (cnt_reg > 7'd1)
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = sum_reg;
                    dreq.divisor  = cnt_reg[5:0];
                    state_next    = S_DIV_WAIT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIV_WAIT:
            begin
                if (drsp.done)
                begin
                    sum_next   = drsp.quotient;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                mean = 17'(sum_reg);
                vsum = mean + 17'(vel_reg);
                // Halve, truncating toward zero.
                vel_next   = 16'((vsum + 17'(vsum[16])) >>> 1);
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                // The output register is loaded only once an earlier result has left.
                if (!(ovalid_reg && out_stall))
                begin
                    odata_next.velocity   = vel_reg;
                    odata_next.used_count = cnt_reg[5:0];
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            newest_reg <= AW'(RING_DEPTH - 1);
            vel_reg    <= '0;
            ovalid_reg <= 1'b0;
            skip_reg   <= 1'b1;
            span_reg   <= 5'd8;
            hist_reg   <= 4'd4;
            thresh_reg <= 6'd8;
        end
        else
        begin
            state_reg  <= state_next;
            newest_reg <= newest_next;
            vel_reg    <= vel_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SKIP:   skip_reg   <= cfg_data[0];
                    CFG_SPAN:   span_reg   <= cfg_data[4:0];
                    CFG_HIST:   hist_reg   <= cfg_data[3:0];
                    CFG_THRESH: thresh_reg <= cfg_data;
                    default:    skip_reg   <= skip_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        k_reg     <= k_next;
        hpass_reg <= hpass_next;
        sum_reg   <= sum_next;
        cnt_reg   <= cnt_next;
        posa_reg  <= posa_next;
        pos_reg   <= pos_next;
        odata_reg <= odata_next;
    end

    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule

// ===== rtl/core/aeve_div.sv =====
module aeve_div (
    input  logic              clk,
    input  logic              rst_n,
    input  aeve_pkg::div_req_t req,
    output aeve_pkg::div_rsp_t rsp
);
    import aeve_pkg::*;

    // Restoring divider on magnitudes, one quotient bit per cycle.
    logic [23:0] rem_q_reg, rem_q_next;
    logic [6:0]  rem_reg, rem_next;
    logic [5:0]  dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [7:0]  trial;

    always_comb
    begin
        rem_q_next = rem_q_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        trial      = {rem_reg, rem_q_reg[23]} - {2'b00, dvs_reg};
        if (req.start)
        begin
            neg_next   = req.dividend[23];
            rem_q_next = req.dividend[23] ? 24'(-req.dividend) : 24'(req.dividend);
            rem_next   = '0;
            dvs_next   = req.divisor;
            cnt_next   = 5'd24;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[7])
            begin
                rem_next   = trial[6:0];
                rem_q_next = {rem_q_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next   = {rem_reg[5:0], rem_q_reg[23]};
                rem_q_next = {rem_q_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_q_reg <= rem_q_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        neg_reg   <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(rem_q_reg) : $signed(rem_q_reg);

endmodule

// ===== rtl/core/aeve_ring.sv =====
module aeve_ring #(
    parameter int RING_DEPTH = aeve_pkg::RING_DEPTH_DEF,
    localparam int AW = $clog2(RING_DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic signed [15:0]   wdata,
    input  logic [AW-1:0]        raddr,
    output logic signed [15:0]   rdata
);
    logic signed [15:0] mem [RING_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== test/aeve_checker.sv =====
module aeve_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  aeve_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  aeve_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data,
    output int                  errors,
    output int                  pending
);
    import aeve_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;

    logic signed [15:0] pos_mem [DEPTH];
    logic [5:0]         head_slot;
    int                 smooth_vel;
    logic               skip_zero;
    logic [4:0]         span;
    logic [3:0]         hist_steps;
    logic [5:0]         threshold;
    out_item_t          velocity_q[$];

    assign pending = velocity_q.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Delta between two slots, wrapped to the 16-bit encoder range.
    function automatic int wrapped_delta(input logic [5:0] later, input logic [5:0] earlier);
        logic signed [15:0] diff;
        diff = pos_mem[later] - pos_mem[earlier];
        return int'(diff);
    endfunction

    // Works out the estimate for one tick and queues it.
    task automatic estimate_velocity();
        logic [5:0] start;
        logic [5:0] top;
        logic [5:0] idx;
        int         n;
        int         sum;
        int         cnt;
        int         delta;
        int         mean;
        out_item_t  res;
        start = head_slot - 6'(span);
        n = (span >= 1) ? int'(span) - 1 : 0;
        sum = 0;
        cnt = 0;
        for (int k = 0; k < n; k++)
        begin
            idx = start + 6'(k);
            delta = wrapped_delta(idx + 6'd1, idx);
            if (!(skip_zero && delta == 0))
            begin
                sum += delta;
                cnt++;
            end
        end
        if (cnt < int'(threshold))
        begin
            top = start - 6'd1;
            for (int k = 0; k < int'(hist_steps); k++)
            begin
                idx = top - 6'(3 * k);
                delta = wrapped_delta(idx + 6'd3, idx);
                if (skip_zero && delta == 0)
                    continue;
                sum += delta;
                cnt += 3;
                if (cnt >= int'(threshold))
                    break;
            end
        end
        mean = (cnt > 1) ? sum / cnt : sum;
        smooth_vel = (mean + smooth_vel) / 2;
        res.velocity = 16'(smooth_vel);
        res.used_count = 6'(cnt);
        velocity_q.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_slot  <= 6'(DEPTH - 1);
            smooth_vel = 0;
            skip_zero  <= 1'b1;
            span       <= 5'd8;
            hist_steps <= 4'd4;
            threshold  <= 6'd8;
            errors     = 0;
            velocity_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (velocity_q.size() == 0)
                    report("unexpected result, velocity", int'(out_data.velocity), 0);
                else
                begin
                    if (out_data.velocity !== velocity_q[0].velocity)
                        report("velocity", int'(out_data.velocity),
                               int'(velocity_q[0].velocity));
                    if (out_data.used_count !== velocity_q[0].used_count)
                        report("used_count", int'(out_data.used_count),
                               int'(velocity_q[0].used_count));
                    void'(velocity_q.pop_front());
                end
            end
            if (in_valid && !in_stall)
            begin
                case (in_data.req_type)
                    REQ_SAMPLE:
                    begin
                        pos_mem[head_slot + 6'd1] = in_data.position;
                        head_slot <= head_slot + 6'd1;
                    end
                    REQ_INIT:
                    begin
                        for (int i = 0; i < DEPTH; i++)
                            pos_mem[i] = in_data.position;
                        head_slot <= 6'(DEPTH - 1);
                        smooth_vel = 0;
                    end
                    REQ_TICK: estimate_velocity();
                    default: ;
                endcase
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SKIP:   skip_zero  <= cfg_data[0];
                    CFG_SPAN:   span       <= cfg_data[4:0];
                    CFG_HIST:   hist_steps <= cfg_data[3:0];
                    CFG_THRESH: threshold  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== test/tb_adaptive_encoder_velocity_estimator.sv =====
// Stimulus and verdict for the encoder velocity estimator. The checker beside
// the block watches every transfer and predicts each tick result.
module tb_adaptive_encoder_velocity_estimator;
    import aeve_pkg::*;

    // Cycles to let a sample or init finish after the last result has come.
    localparam int SETTLE = 200;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;
    logic      cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_SKIP;
    logic [5:0] cfg_data = '0;
    int        errors;
    int        pending;
    logic      no_gaps = 1'b0;
    logic signed [15:0] last_pos = '0;
    int        stall_left = 0;

    always #2 clk = ~clk;

    adaptive_encoder_velocity_estimator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    aeve_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // The receiver stalls in runs of random length, on or off.
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            out_stall  <= ($urandom_range(0, 2) == 0);
            stall_left <= idle_len();
        end
    end

    // One request transfer. Valid stays high across back-to-back transfers.
    task automatic send_req(input logic [1:0] kind, input logic signed [15:0] pos);
        int g;
        g = no_gaps ? 0 : idle_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{req_type: kind, position: pos};
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    // Waits until every tick result has been transferred, then lets any
    // sample or init still in work finish.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Writes all four registers on consecutive edges while the block is idle.
    task automatic set_config(input int skip, input int span, input int hist, input int thr);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SKIP;   cfg_data <= 6'(skip);  @(posedge clk);
        cfg_index <= CFG_SPAN;   cfg_data <= 6'(span);  @(posedge clk);
        cfg_index <= CFG_HIST;   cfg_data <= 6'(hist);  @(posedge clk);
        cfg_index <= CFG_THRESH; cfg_data <= 6'(thr);   @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Position that is often a repeat or a small step, so that zero deltas
    // and short walks both show up, and otherwise anything at all.
    function automatic logic signed [15:0] next_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return last_pos;
        else if (r < 60)
            return last_pos + 16'($urandom_range(0, 6)) - 16'sd3;
        else
            return 16'($urandom);
    endfunction

    task automatic random_phase(input int count);
        int r;
        logic signed [15:0] p;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            p = next_pos();
            if (r < 55)
            begin
                send_req(REQ_SAMPLE, p);
                last_pos = p;
            end
            else if (r < 93)
                send_req(REQ_TICK, 16'($urandom));
            else if (r < 97)
            begin
                send_req(REQ_INIT, p);
                last_pos = p;
            end
            else
                send_req(2'd3, 16'($urandom));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // The ring is filled first, so no tick ever reads an unwritten slot.
        send_req(REQ_INIT, 16'sh7fff);
        send_req(REQ_TICK, '0);
        send_req(REQ_SAMPLE, 16'sh8000);
        send_req(REQ_TICK, '0);
        send_req(REQ_SAMPLE, 16'sh7fff);
        send_req(REQ_SAMPLE, 16'sh7fff);
        send_req(REQ_SAMPLE, 16'sh8000);
        send_req(REQ_TICK, '0);
        send_req(2'd3, 16'shffff);
        send_req(REQ_TICK, '0);
        drain();
        // No zero skipping, span of two, one history step, threshold of one.
        set_config(0, 2, 1, 1);
        send_req(REQ_INIT, 16'sh8000);
        send_req(REQ_SAMPLE, 16'sh0000);
        send_req(REQ_SAMPLE, 16'sh0000);
        send_req(REQ_TICK, '0);
        send_req(REQ_SAMPLE, 16'sh5555);
        send_req(REQ_TICK, '0);
        drain();
        // Longest span, ten history steps, highest threshold.
        set_config(1, 31, 10, 63);
        send_req(REQ_SAMPLE, 16'shaaaa);
        send_req(REQ_SAMPLE, 16'shaaaa);
        send_req(REQ_TICK, '0);
        send_req(REQ_INIT, 16'sh1234);
        send_req(REQ_TICK, '0);
        drain();

        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: set_config(1, 8, 4, 8);
                1: set_config(0, 31, 10, 63);
                2: set_config(1, 2, 10, 63);
                3: set_config(0, 2, 1, 1);
                4: set_config(1, 16, 1, 1);
                5: set_config(0, 5, 3, 20);
                6: set_config(1, 31, 1, 1);
                default: set_config($urandom_range(0, 1), $urandom_range(2, 31),
                                    $urandom_range(1, 10), $urandom_range(1, 63));
            endcase
            no_gaps = (ph % 3 == 1);
            random_phase(210);
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== adaptive_encoder_velocity_estimator.f =====
rtl/core/aeve_pkg.sv
rtl/core/aeve_div.sv
rtl/core/aeve_ring.sv
rtl/core/adaptive_encoder_velocity_estimator.sv
test/aeve_checker.sv
test/tb_adaptive_encoder_velocity_estimator.sv
